/* rtl/core/vvs_pkg.sv */
// ----------------------------------------------------------------------------
// vvs_pkg
// Shared widths, constants, types and the saturating accumulate function of
// the vortex velocity summation block.
// ----------------------------------------------------------------------------
package vvs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int P_W       = 2 * DW;
    localparam int ACC_W     = 64;
    localparam int EPS_W     = 31;
    // Quotient bits needed to tell a saturating quotient from a legal one.
    localparam int QW        = DW + 1;
    localparam int NUM_W     = DW + FRAC_BITS;
    localparam int DEN_W     = P_W + 2 - FRAC_BITS;
    localparam int CNT_W     = $clog2(QW + 1);
    localparam int FM_W      = 35;

    localparam logic [EPS_W-1:0] EPS_RESET   = EPS_W'(655);
    localparam logic [DW-1:0]    INV_2PI_Q32 = DW'(683565276);
    localparam logic [ACC_W-1:0] OUT_CLAMP   = ACC_W'(64'h4_0000_0000);

    typedef logic signed [DW-1:0]    t_q16;
    typedef logic signed [ACC_W-1:0] t_acc;

    typedef struct packed {
        logic start;
        logic neg;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic sat;
    } t_div_rsp;

    typedef struct packed {
        t_acc sum;
        logic sat;
    } t_acc_res;

    function automatic t_acc_res sat_add(input t_acc a, input t_acc b);
        logic signed [ACC_W:0] s;
        t_acc_res              r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            r.sat = 1'b1;
            r.sum = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r.sat = 1'b0;
            r.sum = s[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/vvs_if.sv */
// ----------------------------------------------------------------------------
// vvs_if
// Valid/ready channels of the vortex velocity summation block: vortex
// input, velocity result and configuration write.
// ----------------------------------------------------------------------------
interface vvs_src_if
    import vvs_pkg::*;
();
    logic valid;
    logic ready;
    t_q16 target_x;
    t_q16 target_y;
    t_q16 src_x;
    t_q16 src_y;
    t_q16 src_gamma;
    logic last_source;

    modport source (output valid, target_x, target_y, src_x, src_y, src_gamma,
                    last_source, input ready);
    modport sink   (input valid, target_x, target_y, src_x, src_y, src_gamma,
                    last_source, output ready);
endinterface

interface vvs_vel_if
    import vvs_pkg::*;
();
    logic valid;
    logic ready;
    t_q16 vel_x;
    t_q16 vel_y;
    logic overflow;

    modport source (output valid, vel_x, vel_y, overflow, input ready);
    modport sink   (input valid, vel_x, vel_y, overflow, output ready);
endinterface

interface vvs_cfg_if
    import vvs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [EPS_W-1:0] core_radius_sq;

    modport source (output valid, core_radius_sq, input ready);
    modport sink   (input valid, core_radius_sq, output ready);
endinterface

/* rtl/core/vvs_mul.sv */
// ----------------------------------------------------------------------------
// vvs_mul
// Shared unsigned multiplier with a registered product, one operand pair
// per cycle.
// ----------------------------------------------------------------------------
module vvs_mul
    import vvs_pkg::*;
(
    input  logic           i_clk,
    input  logic [DW-1:0]  i_a,
    input  logic [DW-1:0]  i_b,
    output logic [P_W-1:0] o_p
);

    logic [P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= P_W'(i_a) * P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

/* rtl/core/vvs_div.sv */
// ----------------------------------------------------------------------------
// vvs_div
// Radix-2 restoring divider, one quotient bit per cycle, with saturation of
// the quotient magnitude to the signed 32-bit range.
// ----------------------------------------------------------------------------
module vvs_div
    import vvs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_rsp         o_rsp,
    output logic [DW-1:0]    o_quot
);

    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [QW-1:0]    r_sh;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_fix;
    logic             r_done;
    logic             r_ovf;
    logic             r_neg;
    logic             r_sat;
    logic [DW-1:0]    r_quot;

    logic [DEN_W-1:0] hi_ext;
    logic             ovf;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DW-1:0]    lim;
    logic             q_big;

    // The quotient needs more than QW bits exactly when the bits of the
    // numerator above the quotient field already reach the divisor.
    assign hi_ext = DEN_W'(i_num[NUM_W-1:QW]);
    assign ovf    = hi_ext >= i_den;

    assign trial = {r_rem, r_sh[QW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    assign lim   = r_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    assign q_big = r_ovf || (r_sh > {1'b0, lim});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= ~ovf;
                r_fix  <= ovf;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_den;
            r_neg <= i_req.neg;
            r_rem <= hi_ext;
            r_sh  <= i_num[QW-1:0];
            r_cnt <= CNT_W'(QW);
            r_ovf <= ovf;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_sh  <= {r_sh[QW-2:0], ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end else if (r_fix) begin
            r_quot <= q_big ? lim : r_sh[DW-1:0];
            r_sat  <= q_big;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_quot     = r_quot;

endmodule

/* rtl/core/vortex_velocity_sum.sv */
// ----------------------------------------------------------------------------
// vortex_velocity_sum
// A new vortex is taken only in the idle state, once the last one is through;
// a vortex that closes a sum passes through further states, as the two velocity
// components are scaled on the shared multiplier before the result beat is loaded.
// The 33-step serial divider sets the pace. Synchronous active-low reset
// clears the sums, the flags and the handshakes; core_radius_sq resets to 655.
// ----------------------------------------------------------------------------
module vortex_velocity_sum
    import vvs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    vvs_src_if.sink     i_src,
    vvs_vel_if.source   o_vel,
    vvs_cfg_if.sink     i_cfg
);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'h0001,
        ST_MAG   = 14'h0002,
        ST_SQX   = 14'h0004,
        ST_SQY   = 14'h0008,
        ST_DEN   = 14'h0010,
        ST_DIVST = 14'h0020,
        ST_DIV   = 14'h0040,
        ST_TX    = 14'h0080,
        ST_TY    = 14'h0100,
        ST_ACCY  = 14'h0200,
        ST_FMAG  = 14'h0400,
        ST_FMUL  = 14'h0800,
        ST_FRES  = 14'h1000,
        ST_EMIT  = 14'h2000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [EPS_W-1:0]  r_eps;
    logic signed [DW:0] r_dx;
    logic signed [DW:0] r_dy;
    t_q16              r_g;
    logic              r_last;
    logic [DW-1:0]     r_adx;
    logic [DW-1:0]     r_ady;
    logic              r_dxneg;
    logic              r_dyneg;
    logic [DW-1:0]     r_gmag;
    logic [DEN_W-1:0]  r_den;
    t_acc              r_sum_x;
    t_acc              r_sum_y;
    logic              r_sat;
    logic              r_fsel;
    logic [FM_W-1:0]   r_fm;
    logic              r_fneg;
    logic              r_flag;
    t_q16              r_vx;
    t_q16              r_vy;
    logic              r_ovalid;
    t_q16              r_ovel_x;
    t_q16              r_ovel_y;
    logic              r_oovf;

    logic [DW-1:0]     mul_a;
    logic [DW-1:0]     mul_b;
    logic [P_W-1:0]    prod;
    t_div_req          div_req;
    t_div_rsp          div_rsp;
    logic [DW-1:0]     quot;

    logic              accept;
    logic              out_free;
    logic [DW:0]       dx_abs;
    logic [DW:0]       dy_abs;
    logic [P_W-FRAC_BITS-1:0] pshift;
    t_acc              term_mag;
    logic              neg_x;
    logic              neg_y;
    t_acc_res          acc_x;
    t_acc_res          acc_y;
    t_acc              fin_s;
    logic [ACC_W-1:0]  fin_m;
    logic              fin_clamp;
    logic [P_W:0]      rnd;
    logic [FM_W-1:0]   scaled;
    logic [FM_W-1:0]   fin_lim;
    logic              fin_sat;
    logic [DW-1:0]     fin_r;
    t_q16              fin_v;

    assign accept   = i_src.valid && i_src.ready;
    assign out_free = !r_ovalid || o_vel.ready;

    assign i_src.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_vel.valid    = r_ovalid;
    assign o_vel.vel_x    = r_ovel_x;
    assign o_vel.vel_y    = r_ovel_y;
    assign o_vel.overflow = r_oovf;

    // Operand selection for the shared multiplier; the product is registered and
    // shows up in the state after the one that chose the operands.
    always_comb begin
        unique case (r_state)
            ST_SQX:  begin mul_a = r_adx;             mul_b = r_adx;       end
            ST_SQY:  begin mul_a = r_ady;             mul_b = r_ady;       end
            ST_TX:   begin mul_a = r_ady;             mul_b = quot;        end
            ST_TY:   begin mul_a = r_adx;             mul_b = quot;        end
            ST_FMUL: begin mul_a = r_fm[DW-1:0];      mul_b = INV_2PI_Q32; end
            default: begin mul_a = '0;                mul_b = '0;          end
        endcase
    end

    vvs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign div_req.start = (r_state == ST_DIVST) && (r_den != '0);
    assign div_req.neg   = r_g[DW-1];

    vvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   ({r_gmag, {FRAC_BITS{1'b0}}}),
        .i_den   (r_den),
        .o_rsp   (div_rsp),
        .o_quot  (quot)
    );

    assign dx_abs = r_dx[DW] ? -r_dx : r_dx;
    assign dy_abs = r_dy[DW] ? -r_dy : r_dy;

    assign pshift   = prod[P_W-1:FRAC_BITS];
    assign term_mag = ACC_W'(pshift);

    // The x velocity takes -dy*m, the y velocity dx*m.
    assign neg_x = (r_dyneg == r_g[DW-1]);
    assign neg_y = (r_dxneg != r_g[DW-1]);
    assign acc_x = sat_add(r_sum_x, neg_x ? -term_mag : term_mag);
    assign acc_y = sat_add(r_sum_y, neg_y ? -term_mag : term_mag);

    assign fin_s     = r_fsel ? r_sum_y : r_sum_x;
    assign fin_m     = fin_s[ACC_W-1] ? (~fin_s + ACC_W'(1)) : fin_s;
    assign fin_clamp = fin_m > OUT_CLAMP;

    // The clamped magnitude is wider than one multiplier operand: the low
    // word goes through the multiplier, the top bits are added on here.
    assign rnd     = {1'b0, prod} + (P_W + 1)'(64'h8000_0000);
    assign scaled  = FM_W'(rnd[P_W:DW]) +
                     FM_W'(r_fm[FM_W-1:DW]) * FM_W'(INV_2PI_Q32);
    assign fin_lim = r_fneg ? FM_W'(33'h0_8000_0000) : FM_W'(33'h0_7FFF_FFFF);
    assign fin_sat = scaled > fin_lim;
    assign fin_r   = fin_sat ? fin_lim[DW-1:0] : scaled[DW-1:0];
    assign fin_v   = r_fneg ? -fin_r : fin_r;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept) n_state = ST_MAG;
            ST_MAG:   n_state = ST_SQX;
            ST_SQX:   n_state = ST_SQY;
            ST_SQY:   n_state = ST_DEN;
            ST_DEN:   n_state = ST_DIVST;
            ST_DIVST: begin
                if (r_den != '0) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = r_last ? ST_FMAG : ST_IDLE;
                end
            end
            ST_DIV:   if (div_rsp.done) n_state = ST_TX;
            ST_TX:    n_state = ST_TY;
            ST_TY:    n_state = ST_ACCY;
            ST_ACCY:  n_state = r_last ? ST_FMAG : ST_IDLE;
            ST_FMAG:  n_state = ST_FMUL;
            ST_FMUL:  n_state = ST_FRES;
            ST_FRES:  n_state = r_fsel ? ST_EMIT : ST_FMAG;
            ST_EMIT:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_eps    <= EPS_RESET;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_sat    <= 1'b0;
            r_fsel   <= 1'b0;
            r_flag   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_eps <= i_cfg.core_radius_sq;
            end
            if ((r_state == ST_EMIT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_vel.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_DIVST: begin
                    r_fsel <= 1'b0;
                    if (r_den == '0) begin
                        r_sat <= 1'b1;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_sat <= r_sat | div_rsp.sat;
                    end
                end
                ST_TY: begin
                    r_sum_x <= acc_x.sum;
                    r_sat   <= r_sat | acc_x.sat;
                end
                ST_ACCY: begin
                    r_sum_y <= acc_y.sum;
                    r_sat   <= r_sat | acc_y.sat;
                    r_fsel  <= 1'b0;
                end
                ST_FMAG: begin
                    r_flag <= (r_fsel ? r_flag : r_sat) | fin_clamp;
                end
                ST_FRES: begin
                    r_flag <= r_flag | fin_sat;
                    r_fsel <= ~r_fsel;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_sum_x  <= '0;
                        r_sum_y  <= '0;
                        r_sat    <= 1'b0;
                        r_fsel   <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dx   <= {i_src.target_x[DW-1], i_src.target_x} - {i_src.src_x[DW-1], i_src.src_x};
            r_dy   <= {i_src.target_y[DW-1], i_src.target_y} - {i_src.src_y[DW-1], i_src.src_y};
            r_g    <= i_src.src_gamma;
            r_last <= i_src.last_source;
        end
        if (r_state == ST_MAG) begin
            r_adx   <= dx_abs[DW-1:0];
            r_ady   <= dy_abs[DW-1:0];
            r_dxneg <= r_dx[DW];
            r_dyneg <= r_dy[DW];
            r_gmag  <= r_g[DW-1] ? DW'(-r_g) : DW'(r_g);
        end
        if (r_state == ST_SQY) begin
            r_den <= DEN_W'(pshift) + DEN_W'(r_eps);
        end
        if (r_state == ST_DEN) begin
            r_den <= r_den + DEN_W'(pshift);
        end
        if (r_state == ST_FMAG) begin
            r_fm   <= fin_clamp ? OUT_CLAMP[FM_W-1:0] : fin_m[FM_W-1:0];
            r_fneg <= fin_s[ACC_W-1];
        end
        if (r_state == ST_FRES) begin
            if (r_fsel) begin
                r_vy <= fin_v;
            end else begin
                r_vx <= fin_v;
            end
        end
        if ((r_state == ST_EMIT) && out_free) begin
            r_ovel_x <= r_vx;
            r_ovel_y <= r_vy;
            r_oovf   <= r_flag;
        end
    end

endmodule
